>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: consequent checked in the same cycle
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Non-overlapping implication: consequent checked in the next cycle
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/cbtd_pkg.sv
// ----------------------------------------------------------------------------
// cbtd_pkg
// Widths, register indexes and reset values of the bin target decay block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbtd_pkg;

	// Field widths
	localparam int CLASS_W  = 4;
	localparam int LEN_W    = 16;
	localparam int BATCH_W  = 8;
	localparam int TARGET_W = 8;
	localparam int COUNT_W  = 8;

	// Number of class codes the size_class field can carry
	localparam int NUM_CODES = 2 ** CLASS_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_OVERAGE_LIMIT = 1'd0;
	localparam cfg_idx_t CFG_INIT_LIMIT    = 1'd1;

	// Reset values
	localparam logic [COUNT_W-1:0] OVERAGE_LIMIT_RST = 8'd2;
	localparam logic [LEN_W-1:0]   INIT_LIMIT_RST    = 16'd64;

	// Saturation points
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
	localparam logic [TARGET_W-1:0] TARGET_MAX = 8'd255;

endpackage

`default_nettype wire

>>> sv/cbtd_if.sv
// ----------------------------------------------------------------------------
// cbtd_if
// Valid/ready channels for epoch observations and bin target results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbtd_obs_if import cbtd_pkg::*;;
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] size_class;
	logic [LEN_W-1:0]   bin_length;
	logic [BATCH_W-1:0] refill_size;

	modport source (output valid, size_class, bin_length, refill_size, input ready);
	modport sink   (input valid, size_class, bin_length, refill_size, output ready);
endinterface

interface cbtd_res_if import cbtd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CLASS_W-1:0]  class_out;
	logic [TARGET_W-1:0] trim_target;
	logic [LEN_W-1:0]    length_limit;
	logic                limit_shrank;

	modport source (output valid, class_out, trim_target, length_limit, limit_shrank,
		input ready);
	modport sink   (input valid, class_out, trim_target, length_limit, limit_shrank,
		output ready);
endinterface

`default_nettype wire

>>> sv/cache_bin_target_decay_top.sv
// Pipeline: an accepted word moves from the input stage to the result stage;
// a stalled result holds the result stage and any word in the input stage.
// Throughput: one word per cycle while results are taken; a class's table
// read-modify-write is done as its word enters the result stage, so back-to-back
// words of one class see the updated entry. Reset (arst_n low): overage limit 2,
// every class limit 64, counts and stored last lengths zero, both stages empty.
// ----------------------------------------------------------------------------
// cache_bin_target_decay_top
// Per-class length limit decay and bin trim target computation.
// ----------------------------------------------------------------------------
`default_nettype none

module cache_bin_target_decay_top import cbtd_pkg::*; #(
	parameter int NUM_CLASSES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	cbtd_obs_if.sink              obs,
	cbtd_res_if.source            res
);

	// Only classes the input field can address need storage
	localparam int DEPTH = (NUM_CLASSES < NUM_CODES) ? NUM_CLASSES : NUM_CODES;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration registers
	logic [COUNT_W-1:0] overage_limit_q;
	logic [LEN_W-1:0]   init_limit_q;

	// Class tables
	logic [LEN_W-1:0]   limit_tab_q [DEPTH];
	logic [COUNT_W-1:0] over_tab_q  [DEPTH];
	logic [LEN_W-1:0]   low_tab_q   [DEPTH];

	// Input stage
	logic               valid_s1;
	logic [CLASS_W-1:0] class_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [BATCH_W-1:0] batch_s1;

	// Result stage
	logic                out_valid_q;
	logic [CLASS_W-1:0]  class_q;
	logic [TARGET_W-1:0] target_q;
	logic [LEN_W-1:0]    limit_q;
	logic                shrank_q;

	// Combinational step
	logic               advance;
	logic               in_range;
	logic [IDX_W-1:0]   idx;
	logic [LEN_W-1:0]   cur_limit;
	logic [COUNT_W-1:0] cur_over;
	logic [LEN_W-1:0]   cur_low;
	logic [LEN_W-1:0]   batch_ext;
	logic               over;
	logic [COUNT_W-1:0] cnt_inc;
	logic               hit;
	logic [LEN_W-1:0]   new_limit;
	logic [COUNT_W-1:0] new_over;
	logic [LEN_W-1:0]   low;
	logic [LEN_W-2:0]   half;
	logic [LEN_W-2:0]   floored;
	logic [TARGET_W-1:0] target;

	// Handshake: the result register frees the input stage
	assign advance   = !out_valid_q || res.ready;
	assign obs.ready = !valid_s1 || advance;

	// Read the class entry
	assign in_range  = 32'(class_s1) < NUM_CLASSES;
	assign idx       = class_s1[IDX_W-1:0];
	assign cur_limit = in_range ? limit_tab_q[idx] : '0;
	assign cur_over  = in_range ? over_tab_q[idx]  : '0;
	assign cur_low   = in_range ? low_tab_q[idx]   : '0;
	assign batch_ext = {{(LEN_W-BATCH_W){1'b0}}, batch_s1};

	// Count overages and shrink the limit
	always_comb begin
		over     = len_s1 > cur_limit;
		cnt_inc  = (cur_over == COUNT_MAX) ? cur_over : cur_over + 8'd1;
		hit      = over && (cnt_inc >= overage_limit_q);
		new_limit = (hit && (cur_limit > batch_ext)) ? cur_limit - batch_ext : cur_limit;
		if (!over || hit) begin
			new_over = '0;
		end else begin
			new_over = cnt_inc;
		end
	end

	// Form the trim target from the lower of this length and the class's stored last length
	always_comb begin
		low     = ((len_s1 < cur_low) || (cur_low == '0)) ? len_s1 : cur_low;
		half    = low[LEN_W-1:1];
		floored = (half < batch_ext[LEN_W-2:0]) ? batch_ext[LEN_W-2:0] : half;
		target  = (floored > {{(LEN_W-1-TARGET_W){1'b0}}, TARGET_MAX}) ?
			TARGET_MAX : floored[TARGET_W-1:0];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overage_limit_q <= OVERAGE_LIMIT_RST;
			init_limit_q    <= INIT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OVERAGE_LIMIT: overage_limit_q <= cfg_data[COUNT_W-1:0];
				CFG_INIT_LIMIT:    init_limit_q    <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// Update tables: reload all on an initial limit write, else write back the stepped class
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				limit_tab_q[i] <= INIT_LIMIT_RST;
				over_tab_q[i]  <= '0;
				low_tab_q[i]   <= '0;
			end
		end else if (cfg_we && (cfg_index == CFG_INIT_LIMIT)) begin
			for (int i = 0; i < DEPTH; i++) begin
				limit_tab_q[i] <= cfg_data[LEN_W-1:0];
				over_tab_q[i]  <= '0;
				low_tab_q[i]   <= '0;
			end
		end else if (valid_s1 && advance && in_range) begin
			limit_tab_q[idx] <= new_limit;
			over_tab_q[idx]  <= new_over;
			low_tab_q[idx]   <= len_s1;
		end
	end

	// Input stage: capture the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (obs.valid && obs.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (obs.valid && obs.ready) begin
			class_s1 <= obs.size_class;
			len_s1   <= obs.bin_length;
			batch_s1 <= obs.refill_size;
		end
	end

	// Result stage: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			class_q  <= class_s1;
			target_q <= in_range ? target : '0;
			limit_q  <= in_range ? new_limit : '0;
			shrank_q <= in_range && hit;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.class_out    = class_q;
	assign res.trim_target  = target_q;
	assign res.length_limit = limit_q;
	assign res.limit_shrank = shrank_q;

endmodule

`default_nettype wire

>>> sv/cbtd_checker.sv
// ----------------------------------------------------------------------------
// cbtd_checker
// Port-level checks of the bin target decay block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbtd_checker import cbtd_pkg::*; #(
	parameter int NUM_CLASSES = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                obs_valid,
	input logic                obs_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic [CLASS_W-1:0]  res_class_out,
	input logic [TARGET_W-1:0] res_trim_target,
	input logic [LEN_W-1:0]    res_length_limit,
	input logic                res_limit_shrank
);

	// A stalled result holds its word
	`ASSERT_NXT(a_res_hold, res_valid && !res_ready,
		res_valid && $stable({res_class_out, res_trim_target, res_length_limit,
		res_limit_shrank}), "result word changed while stalled")

	// Back-pressure only while a result waits
	`ASSERT_IMP(a_ready_full, !obs_ready, res_valid, "input stalled with empty result register")

	// After an accepted word passes the input stage, the result register is valid
	`ASSERT_IMP(a_latency, obs_valid && obs_ready, ##2 res_valid, "accepted word produced no result")

	// Unknown classes report a zero target, a zero limit and no shrink
	`ASSERT_IMP(a_bad_class, res_valid && (32'(res_class_out) >= NUM_CLASSES),
		(res_trim_target == '0) && (res_length_limit == '0) && !res_limit_shrank,
		"nonzero result for out-of-range class")

endmodule

bind cache_bin_target_decay_top cbtd_checker #(.NUM_CLASSES(NUM_CLASSES)) u_cbtd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.obs_valid        (obs.valid),
	.obs_ready        (obs.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_class_out    (res.class_out),
	.res_trim_target  (res.trim_target),
	.res_length_limit (res.length_limit),
	.res_limit_shrank (res.limit_shrank)
);

`default_nettype wire
